// ----- sv/utf8f_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8f_pkg
// Item types and byte-class constants for the UTF-8 sequence filter.
// ----------------------------------------------------------------------------
package utf8f_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       stream_end;
   } rsp_item_type;

   localparam int unsigned MAX_RESULTS = 4;

   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

endpackage

// ----- sv/utf8_sequence_filter.sv -----
// ----------------------------------------------------------------------------
// utf8_sequence_filter
// Structural UTF-8 filter: passes ASCII bytes and complete, well-formed
// 2/3/4 byte sequences, drops everything else, and flags the stream end.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload        handshake
//   -------  ---------  -------------  -------------------------------
//   req      in         req_item_type  req_valid / req_stall (ours)
//   rsp      out        rsp_item_type  rsp_valid / rsp_stall (theirs)
//
// An accepted item is held in the input register, then its results
// (zero to four) load a burst buffer that drains one result per cycle
// while rsp_stall is low; the first result reaches the rsp port from
// the burst register, behind the input register. One item enters per
// cycle unless req_stall holds it; an item that yields results waits in
// the input register until the burst buffer is empty, or down to its last
// entry and that entry is taken, and so waits while rsp_stall is high.
// Lead and middle bytes of a sequence never wait unless they end the stream.
// Reset clears the valid flags, the burst count and the sequence state.
// ----------------------------------------------------------------------------
module utf8_sequence_filter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  utf8f_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output utf8f_pkg::rsp_item_type rsp_data
);
   import utf8f_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   // sequence state
   logic [2:0] seq_length_ff, seq_length_in;
   logic [1:0] bytes_pending_ff, bytes_pending_in;
   logic       seq_ok_ff, seq_ok_in;
   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];

   // burst buffer: entry 0 is the result on the rsp port
   rsp_item_type burst_ff [MAX_RESULTS];
   rsp_item_type burst_in [MAX_RESULTS];
   logic [2:0]   burst_cnt_ff, burst_cnt_in;

   // per-item results
   rsp_item_type res [MAX_RESULTS];
   logic [2:0]   res_cnt;
   logic [7:0]   data_sel [MAX_RESULTS];
   logic [7:0]   b;
   logic         is_cont, bare, advance, burst_free, rsp_accept, req_accept;
   logic [2:0]   pos;

   assign rsp_accept = rsp_valid & ~rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = (burst_cnt_ff != 3'd0);
   assign rsp_data   = burst_ff[0];

   // Burst buffer can take a new load when empty or emptying this cycle.
   assign burst_free = (burst_cnt_ff == 3'd0) | ((burst_cnt_ff == 3'd1) & rsp_accept);
   assign advance    = in_valid_ff & ((res_cnt == 3'd0) | burst_free);
   assign req_stall  = in_valid_ff & ~advance;

   assign b       = in_item_ff.data_byte;
   assign is_cont = ((b & CONT_MASK) == CONT_TAG);
   assign pos     = seq_length_ff - {1'b0, bytes_pending_ff};

   // Sequence bytes in order: held bytes first, current byte last.
   assign data_sel[0] = (seq_length_ff > 3'd1) ? held_ff[0] : b;
   assign data_sel[1] = (seq_length_ff > 3'd2) ? held_ff[1] : b;
   assign data_sel[2] = (seq_length_ff > 3'd3) ? held_ff[2] : b;
   assign data_sel[3] = b;

   always_comb begin
      logic [2:0] n;
      n                = 3'd0;
      seq_length_in    = seq_length_ff;
      bytes_pending_in = bytes_pending_ff;
      seq_ok_in        = seq_ok_ff;
      held_in          = held_ff;

      if (seq_length_ff == LEN_NONE) begin
         // classify a byte outside a sequence; bad leads drop silently
         if (b <= ASCII_MAX) begin
            n = 3'd1;
         end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            seq_length_in = LEN_TWO;
         end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            seq_length_in = LEN_THREE;
         end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            seq_length_in = LEN_FOUR;
         end
         if (seq_length_in != LEN_NONE) begin
            held_in[0]       = b;
            bytes_pending_in = seq_length_in[1:0] - 2'd1;
            seq_ok_in        = 1'b1;
         end
      end else begin
         // any byte counts toward the open sequence; a bad one spoils it
         seq_ok_in = seq_ok_ff & is_cont;
         if (bytes_pending_ff > 2'd1) begin
            case (pos)
               3'd1:    held_in[1] = b;
               3'd2:    held_in[2] = b;
               default: ;
            endcase
            bytes_pending_in = bytes_pending_ff - 2'd1;
         end else begin
            if (seq_ok_in) begin
               n = seq_length_ff;
            end
            seq_length_in    = LEN_NONE;
            bytes_pending_in = 2'd0;
            seq_ok_in        = 1'b1;
         end
      end

      bare = 1'b0;
      if (in_item_ff.stream_last) begin
         // drop any truncated sequence; always emit something at the end
         seq_length_in    = LEN_NONE;
         bytes_pending_in = 2'd0;
         seq_ok_in        = 1'b1;
         if (n == 3'd0) begin
            n    = 3'd1;
            bare = 1'b1;
         end
      end
      res_cnt = n;

      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i].out_byte   = bare ? 8'h00 : data_sel[i];
         res[i].byte_valid = ~bare;
         res[i].run_last   = (3'(i) == (n - 3'd1));
         res[i].stream_end = in_item_ff.stream_last;
      end
   end

   // Load a new burst, or shift the drained entry out.
   always_comb begin
      burst_in     = burst_ff;
      burst_cnt_in = burst_cnt_ff;
      if (advance && (res_cnt != 3'd0)) begin
         burst_in     = res;
         burst_cnt_in = res_cnt;
      end else if (rsp_accept) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            burst_in[i] = burst_ff[i + 1];
         end
         burst_cnt_in = burst_cnt_ff - 3'd1;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         burst_cnt_ff     <= 3'd0;
         seq_length_ff    <= LEN_NONE;
         bytes_pending_ff <= 2'd0;
         seq_ok_ff        <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         burst_cnt_ff <= burst_cnt_in;
         if (advance) begin
            seq_length_ff    <= seq_length_in;
            bytes_pending_ff <= bytes_pending_in;
            seq_ok_ff        <= seq_ok_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         held_ff <= held_in;
      end
      burst_ff <= burst_in;
   end

endmodule

// ----- dv/utf8_filter_checker.sv -----
// ----------------------------------------------------------------------------
// utf8_filter_checker
// Watches both channels of the UTF-8 sequence filter, predicts the results
// of every accepted byte and compares each accepted result against them.
// ----------------------------------------------------------------------------
module utf8_filter_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  utf8f_pkg::req_item_type req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  utf8f_pkg::rsp_item_type rsp_data,
   output int                      error_count,
   output int                      owed_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import utf8f_pkg::*;

   // sequence tracker of the filter
   logic [2:0] open_len;
   logic [1:0] conts_left;
   logic       conts_good;
   logic [7:0] held_byte [3];

   rsp_item_type due_output [$];

   function automatic rsp_item_type data_rsp(input logic [7:0] b);
      rsp_item_type r;
      r = '0;
      r.out_byte = b;
      r.byte_valid = 1'b1;
      return r;
   endfunction

   function automatic void close_seq();
      open_len = LEN_NONE;
      conts_left = 2'd0;
      conts_good = 1'b1;
   endfunction

   // Work out what one accepted byte releases and queue it.
   function automatic void filter_byte(input req_item_type item);
      rsp_item_type burst [$];
      rsp_item_type marker;
      logic [7:0]   b;
      logic [2:0]   len;
      logic [2:0]   pos;
      b = item.data_byte;
      if (open_len == LEN_NONE) begin
         len = LEN_NONE;
         if (b <= ASCII_MAX) begin
            burst = {burst, data_rsp(b)};
         end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            len = LEN_TWO;
         end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            len = LEN_THREE;
         end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            len = LEN_FOUR;
         end
         if (len != LEN_NONE) begin
            held_byte[0] = b;
            open_len = len;
            conts_left = 2'(len - 3'd1);
            conts_good = 1'b1;
         end
      end else begin
         pos = open_len - 3'(conts_left);
         // any byte inside a sequence is consumed by it, good or not
         if ((b & CONT_MASK) != CONT_TAG)
            conts_good = 1'b0;
         if (conts_left > 2'd1) begin
            held_byte[pos[1:0]] = b;
            conts_left = conts_left - 2'd1;
         end else begin
            if (conts_good) begin
               for (int i = 0; i < int'(open_len) - 1; i++)
                  burst = {burst, data_rsp(held_byte[i])};
               burst = {burst, data_rsp(b)};
            end
            close_seq();
         end
      end
      if (item.stream_last) begin
         // drop any truncated sequence; a silent final byte still gets a marker
         close_seq();
         if (burst.size() == 0) begin
            marker = '0;
            burst = {burst, marker};
         end
         foreach (burst[k])
            burst[k].stream_end = 1'b1;
      end
      if (burst.size() != 0)
         burst[burst.size() - 1].run_last = 1'b1;
      due_output = {due_output, burst};
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         close_seq();
         due_output.delete();
         error_count = 0;
      end else begin
         if (req_valid && !req_stall)
            filter_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (due_output.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result: expected none, actual %p",
                        $time, rsp_data);
            end else begin
               want = due_output.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_data.byte_valid));
               check_field("run_last", 8'(want.run_last), 8'(rsp_data.run_last));
               check_field("stream_end", 8'(want.stream_end), 8'(rsp_data.stream_end));
            end
         end
      end
      owed_count = due_output.size();
   end

endmodule

// ----- dv/tb_utf8_sequence_filter.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_sequence_filter
// Drives the UTF-8 sequence filter with directed and random byte runs under
// random idling on both channels and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_utf8_sequence_filter;

   timeunit 1ns;
   timeprecision 1ps;

   import utf8f_pkg::*;

   localparam int RANDOM_ITEMS   = 275;
   localparam int PHASE_ITEMS    = 40;
   localparam int LONG_HOLD      = 150;   // receiver hold-off that backs up the block
   localparam int DRAIN_CYCLES   = 16;    // input and burst registers plus a full burst, padded
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side

   typedef enum {RUN_ASCII, RUN_SEQ, RUN_BROKEN, RUN_NOISE} run_kind_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   int error_count;
   int owed_count;
   int quiet_cycles = 0;

   // phase knobs set by the stimulus and read by the sender and the receiver
   bit tx_calm       = 1'b0;
   bit rx_calm       = 1'b0;
   bit long_hold_req = 1'b0;

   always #6 clock = ~clock;

   utf8_sequence_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   utf8_filter_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .owed_count  (owed_count)
   );

   // Offer one byte after a random gap and hold it until the block takes it.
   // Entered right after an edge of the clock; every change lands on a falling
   // edge, and req_valid is never driven to both levels on the same falling edge.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = tx_calm ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.data_byte <= b;
      req_data.stream_last <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Receiver: draw a hold-off per item, then take one item. The long
   // hold-off is served once, counted in this process.
   initial begin
      int unsigned hold;
      bit          hold_served;
      hold_served = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_served) begin
            hold = LONG_HOLD;
            hold_served = 1'b1;
         end else begin
            hold = rx_calm ? 0 : $urandom_range(0, 9);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [8:0]   opening [25];
      logic [7:0]   run [$];
      logic [7:0]   rnd;
      logic [2:0]   seq_len;
      run_kind_type kind;
      int unsigned  pick;
      int           last_at;
      int           counted;
      int           phase_mark;
      bit           pressure_done;

      // {stream_last, data_byte}
      opening = '{
         // ASCII extremes
         {1'b0, 8'h00}, {1'b0, 8'h7F},
         // well-formed two, three and four byte sequences
         {1'b0, 8'hC2}, {1'b0, 8'hA9},
         {1'b0, 8'hE2}, {1'b0, 8'h82}, {1'b0, 8'hAC},
         {1'b0, 8'hF7}, {1'b0, 8'hBF}, {1'b0, 8'hBF}, {1'b0, 8'h80},
         // invalid lead bytes outside a sequence
         {1'b0, 8'h80}, {1'b0, 8'hBF}, {1'b0, 8'hF8}, {1'b0, 8'hFF},
         // ASCII inside a three-byte sequence: consumed, whole sequence dropped
         {1'b0, 8'hE2}, {1'b0, 8'h41}, {1'b0, 8'h80},
         // lead byte in the continuation slot
         {1'b0, 8'hC3}, {1'b0, 8'hC3},
         // final byte completing a sequence
         {1'b0, 8'hD0}, {1'b1, 8'hBF},
         // truncated sequence at stream end: bare end marker
         {1'b0, 8'hF4}, {1'b1, 8'h8F},
         // final ASCII byte
         {1'b1, 8'h41}
      };

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (opening[i])
         send_byte(opening[i][7:0], opening[i][8]);

      // Random runs: ASCII bytes, well-formed sequences with random payload
      // bits, some broken sequences and stray bytes, and the odd stream end that
      // may cut a sequence short. Phases switch idling on and off.
      counted = 0;
      phase_mark = 0;
      pressure_done = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         if (counted >= phase_mark) begin
            tx_calm = ($urandom_range(0, 2) == 0);
            rx_calm = ($urandom_range(0, 2) == 0);
            if (!pressure_done && counted >= 3 * PHASE_ITEMS) begin
               // keep offering bytes back to back while the receiver holds off
               tx_calm = 1'b1;
               long_hold_req = 1'b1;
               pressure_done = 1'b1;
            end
            phase_mark = phase_mark + PHASE_ITEMS;
         end

         pick = $urandom_range(0, 9);
         if (pick < 3)
            kind = RUN_ASCII;
         else if (pick < 7)
            kind = RUN_SEQ;
         else if (pick < 8)
            kind = RUN_BROKEN;
         else
            kind = RUN_NOISE;

         run.delete();
         case (kind)
            RUN_ASCII: begin
               run = {run, 8'($urandom_range(0, 127))};
            end
            RUN_NOISE: begin
               run = {run, 8'($urandom_range(0, 255))};
            end
            default: begin
               pick = $urandom_range(0, 2);
               seq_len = (pick == 0) ? LEN_TWO : (pick == 1) ? LEN_THREE : LEN_FOUR;
               rnd = 8'($urandom);
               case (seq_len)
                  LEN_TWO:   run = {run, {3'b110, rnd[4:0]}};
                  LEN_THREE: run = {run, {4'b1110, rnd[3:0]}};
                  default:   run = {run, {5'b11110, rnd[2:0]}};
               endcase
               repeat (int'(seq_len) - 1) begin
                  rnd = 8'($urandom);
                  run = {run, {2'b10, rnd[5:0]}};
               end
               // spoil one continuation slot with any byte at all
               if (kind == RUN_BROKEN)
                  run[$urandom_range(1, int'(seq_len) - 1)] = 8'($urandom_range(0, 255));
            end
         endcase

         last_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, run.size() - 1) : -1;
         foreach (run[i])
            send_byte(run[i], i == last_at);
         counted = counted + run.size();
      end

      // close the stream so the last results carry the end flag
      send_byte(8'($urandom_range(0, 127)), 1'b1);
      @(negedge clock);
      req_valid <= 1'b0;

      // drain: wait for every predicted result, then watch for strays
      while (owed_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
